// File: design/ptvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptvs_pkg
// Shared types and constants of the page table with victim selection.
// ----------------------------------------------------------------------------
package ptvs_pkg;

  localparam int OPCODE_W   = 3;
  localparam int PAGE_IDX_W = 8;
  localparam int FRAME_W    = 5;
  localparam int CNT_W      = 32;

  localparam int PAGES_DEF  = 256;
  localparam int FRAMES_DEF = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOOKUP = 3'd0,
    OP_SET    = 3'd1,
    OP_UNSET  = 3'd2,
    OP_SET_RO = 3'd3,
    OP_FIND   = 3'd4,
    OP_VICTIM = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_REDUCE,
    S_SCAN,
    S_PAGE,
    S_ENTRY
  } state_t;

  typedef struct packed {
    logic               valid;
    logic               ro;
    logic [FRAME_W-1:0] frame;
  } entry_t;

endpackage

// File: design/ptvs_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptvs_in_if / ptvs_out_if
// Valid/ready channels for operation requests and their results.
// ----------------------------------------------------------------------------
interface ptvs_in_if import ptvs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [OPCODE_W-1:0]   opcode;
  logic [PAGE_IDX_W-1:0] page_index;
  logic [FRAME_W-1:0]    frame_in;
  logic                  readonly_value;
  logic [PAGE_IDX_W-1:0] random_start;
  logic [FRAME_W-1:0]    random_frame;

  modport source (
    output valid, opcode, page_index, frame_in, readonly_value, random_start,
           random_frame,
    input  ready
  );
  modport sink (
    input  valid, opcode, page_index, frame_in, readonly_value, random_start,
           random_frame,
    output ready
  );
endinterface

interface ptvs_out_if import ptvs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FRAME_W-1:0]    frame_out;
  logic                  hit;
  logic [PAGE_IDX_W-1:0] page_out;
  logic                  entry_valid;
  logic                  entry_readonly;
  logic [CNT_W-1:0]      lookups_seen;
  logic [CNT_W-1:0]      faults_seen;
  logic [CNT_W-1:0]      sets_seen;

  modport source (
    output valid, frame_out, hit, page_out, entry_valid, entry_readonly,
           lookups_seen, faults_seen, sets_seen,
    input  ready
  );
  modport sink (
    input  valid, frame_out, hit, page_out, entry_valid, entry_readonly,
           lookups_seen, faults_seen, sets_seen,
    output ready
  );
endinterface

// File: design/page_table_with_victim_select_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_table_with_victim_select_core
// Page table of PAGES entries (valid, readonly, frame) in one synchronous
// memory, with lookup, update, frame search and victim selection.
//
// in_ch carries one operation per transfer; out_ch returns exactly one result
// per operation, in order. After reset a clearing pass writes every entry to
// zero, one per cycle; in_ch.ready stays low meanwhile. Lookup, set, unset,
// set readonly and unused opcodes read their entry in S_IDLE, then update it
// and load the result in S_ENTRY. Find page scans the memory from page 0,
// one read per cycle. Victim first reduces its random start and frame, then
// scans circularly from the reduced start page. The single memory read port
// sets the pace of both scans. One operation is in work at a time. The result
// sits in an output register, so the next operation is accepted while it
// waits; a stalled receiver holds the block only when the next result is
// ready to be loaded.
// ----------------------------------------------------------------------------
module page_table_with_victim_select_core import ptvs_pkg::*; #(
  parameter int PAGES  = PAGES_DEF,
  parameter int FRAMES = FRAMES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ptvs_in_if.sink   in_ch,
  ptvs_out_if.source out_ch
);

  localparam int PW = $clog2(PAGES);
  localparam logic [PW-1:0] LAST = PW'(PAGES - 1);

  entry_t mem [PAGES];
  entry_t rd_data_r;
  logic [PW-1:0] rd_addr;
  logic          mem_we;
  logic [PW-1:0] mem_waddr;
  entry_t        mem_wdata;

  state_t state_r, state_nxt;
  logic [PW-1:0] clr_addr_r, clr_addr_nxt;
  logic [PW-1:0] scan_addr_r, scan_addr_nxt;
  logic [PW-1:0] chk_addr_r, chk_addr_nxt;
  logic [PW-1:0] chk_cnt_r, chk_cnt_nxt;
  logic          chk_vld_r, chk_vld_nxt;
  logic          res_hit_r, res_hit_nxt;
  logic [FRAME_W-1:0]    res_frame_r, res_frame_nxt;
  logic [PAGE_IDX_W-1:0] res_page_r, res_page_nxt;
  logic [CNT_W-1:0] lookups_r, lookups_nxt;
  logic [CNT_W-1:0] faults_r, faults_nxt;
  logic [CNT_W-1:0] sets_r, sets_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [OPCODE_W-1:0]   op_r;
  logic [FRAME_W-1:0]    frame_r;
  logic                  ro_r;
  logic [PW-1:0]         page_addr_r;
  logic                  inrange_r;

  logic in_fire, out_free, out_load, red_load, red_done;
  logic [PAGE_IDX_W-1:0] red_start;
  logic [FRAME_W-1:0]    red_frame;
  logic scan_match;

  entry_t ent_new;
  logic   ent_we, ent_hit, inc_lookup, inc_fault, inc_set;
  logic [FRAME_W-1:0] ent_frame;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  ptvs_reduce #(.PAGES(PAGES), .FRAMES(FRAMES)) u_reduce (
    .clk       (clk),
    .load      (red_load),
    .start_in  (in_ch.random_start),
    .frame_in  (in_ch.random_frame),
    .done      (red_done),
    .start_out (red_start),
    .frame_out (red_frame)
  );

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    scan_match = (op_r == OP_FIND) ? (rd_data_r.frame == frame_r)
                                   : (rd_data_r.valid && !rd_data_r.ro);
  end

  // read-modify-write of the addressed entry, with result and counter flags per opcode
  always_comb begin
    ent_new    = rd_data_r;
    ent_we     = 1'b0;
    ent_hit    = 1'b0;
    ent_frame  = '0;
    inc_lookup = 1'b0;
    inc_fault  = 1'b0;
    inc_set    = 1'b0;
    unique case (op_r)
      OP_LOOKUP: begin
        inc_lookup = 1'b1;
        if (inrange_r && rd_data_r.valid) begin
          ent_hit   = 1'b1;
          ent_frame = rd_data_r.frame;
        end else begin
          inc_fault = 1'b1;
        end
      end
      OP_SET: begin
        inc_set = 1'b1;
        ent_new = '{valid: 1'b1, ro: 1'b1, frame: frame_r};
        ent_we  = inrange_r;
      end
      OP_UNSET: begin
        ent_new.valid = 1'b0;
        ent_we        = inrange_r;
      end
      OP_SET_RO: begin
        ent_new.ro = ro_r;
        ent_we     = inrange_r;
      end
      OP_FIND: begin
        ent_hit = res_hit_r;
      end
      OP_VICTIM: begin
        ent_hit   = res_hit_r;
        ent_frame = res_frame_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    scan_addr_nxt = scan_addr_r;
    chk_addr_nxt  = chk_addr_r;
    chk_cnt_nxt   = chk_cnt_r;
    chk_vld_nxt   = chk_vld_r;
    res_hit_nxt   = res_hit_r;
    res_frame_nxt = res_frame_r;
    res_page_nxt  = res_page_r;
    lookups_nxt   = lookups_r;
    faults_nxt    = faults_r;
    sets_nxt      = sets_r;
    rd_addr       = page_addr_r;
    mem_we        = 1'b0;
    mem_waddr     = clr_addr_r;
    mem_wdata     = '0;
    red_load      = 1'b0;
    out_load      = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr_r == LAST) state_nxt = S_IDLE;
        else clr_addr_nxt = clr_addr_r + 1'b1;
      end
      S_IDLE: begin
        rd_addr       = PW'(in_ch.page_index);
        res_hit_nxt   = 1'b0;
        res_frame_nxt = '0;
        res_page_nxt  = '0;
        scan_addr_nxt = '0;
        chk_cnt_nxt   = '0;
        chk_vld_nxt   = 1'b0;
        if (in_fire) begin
          unique case (in_ch.opcode)
            OP_FIND:   state_nxt = S_SCAN;
            OP_VICTIM: begin
              red_load  = 1'b1;
              state_nxt = S_REDUCE;
            end
            default:   state_nxt = S_ENTRY;
          endcase
        end
      end
      S_REDUCE: begin
        if (red_done) begin
          scan_addr_nxt = PW'(red_start);
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_addr       = scan_addr_r;
        scan_addr_nxt = (scan_addr_r == LAST) ? '0 : scan_addr_r + 1'b1;
        chk_addr_nxt  = scan_addr_r;
        chk_vld_nxt   = 1'b1;
        if (chk_vld_r) begin
          if (scan_match) begin
            res_hit_nxt = 1'b1;
            if (op_r == OP_VICTIM) res_frame_nxt = rd_data_r.frame;
            else res_page_nxt = PAGE_IDX_W'(chk_addr_r);
            state_nxt = S_PAGE;
          end else if (chk_cnt_r == LAST) begin
            if (op_r == OP_VICTIM) res_frame_nxt = red_frame;
            state_nxt = S_PAGE;
          end else begin
            chk_cnt_nxt = chk_cnt_r + 1'b1;
          end
        end
      end
      S_PAGE: begin
        state_nxt = S_ENTRY;
      end
      S_ENTRY: begin
        if (out_free) begin
          out_load  = 1'b1;
          mem_we    = ent_we;
          mem_waddr = page_addr_r;
          mem_wdata = ent_new;
          if (inc_lookup && lookups_r != '1) lookups_nxt = lookups_r + 1'b1;
          if (inc_fault && faults_r != '1)   faults_nxt  = faults_r + 1'b1;
          if (inc_set && sets_r != '1)       sets_nxt    = sets_r + 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      chk_vld_r   <= 1'b0;
      lookups_r   <= '0;
      faults_r    <= '0;
      sets_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      chk_vld_r   <= chk_vld_nxt;
      lookups_r   <= lookups_nxt;
      faults_r    <= faults_nxt;
      sets_r      <= sets_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_addr_r <= scan_addr_nxt;
    chk_addr_r  <= chk_addr_nxt;
    chk_cnt_r   <= chk_cnt_nxt;
    res_hit_r   <= res_hit_nxt;
    res_frame_r <= res_frame_nxt;
    res_page_r  <= res_page_nxt;
    if (in_fire) begin
      op_r        <= in_ch.opcode;
      frame_r     <= in_ch.frame_in;
      ro_r        <= in_ch.readonly_value;
      page_addr_r <= PW'(in_ch.page_index);
      inrange_r   <= {{(32-PAGE_IDX_W){1'b0}}, in_ch.page_index} < 32'(PAGES);
    end
    if (out_load) begin
      out_ch.frame_out      <= ent_frame;
      out_ch.hit            <= ent_hit;
      out_ch.page_out       <= res_page_r;
      out_ch.entry_valid    <= inrange_r && ent_new.valid;
      out_ch.entry_readonly <= inrange_r && ent_new.ro;
      out_ch.lookups_seen   <= lookups_nxt;
      out_ch.faults_seen    <= faults_nxt;
      out_ch.sets_seen      <= sets_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;

  // faults are only ever counted together with a lookup
  a_faults_le_lookups: assert property (@(posedge clk) disable iff (!rst_n)
    faults_r <= lookups_r)
    else $error("fault count exceeds lookup count");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (chk_cnt_r <= LAST && scan_addr_r <= LAST))
    else $error("scan ran past the table");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (state_r == S_ENTRY && !(in_fire)))
    else $error("result loaded outside entry update");

endmodule

// File: design/ptvs_reduce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptvs_reduce
// Iterative reduction of the random start page modulo PAGES and of the
// fallback frame modulo FRAMES, one subtraction per cycle each.
// ----------------------------------------------------------------------------
module ptvs_reduce import ptvs_pkg::*; #(
  parameter int PAGES  = PAGES_DEF,
  parameter int FRAMES = FRAMES_DEF
) (
  input  logic                  clk,
  input  logic                  load,
  input  logic [PAGE_IDX_W-1:0] start_in,
  input  logic [FRAME_W-1:0]    frame_in,
  output logic                  done,
  output logic [PAGE_IDX_W-1:0] start_out,
  output logic [FRAME_W-1:0]    frame_out
);

  logic [PAGE_IDX_W-1:0] start_r;
  logic [FRAME_W-1:0]    frame_r;
  logic                  start_big;
  logic                  frame_big;

  assign start_big = {{(32-PAGE_IDX_W){1'b0}}, start_r} >= 32'(PAGES);
  assign frame_big = {{(32-FRAME_W){1'b0}}, frame_r} >= 32'(FRAMES);

  always_ff @(posedge clk) begin
    if (load) begin
      start_r <= start_in;
      frame_r <= frame_in;
    end else begin
      if (start_big) start_r <= start_r - PAGE_IDX_W'(PAGES);
      if (frame_big) frame_r <= frame_r - FRAME_W'(FRAMES);
    end
  end

  assign done      = !start_big && !frame_big;
  assign start_out = start_r;
  assign frame_out = frame_r;

endmodule

// File: dv/page_table_with_victim_select_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_table_with_victim_select_core_test
// Self-checking bench for the page table core. Operations go in over the
// request channel. A shadow page table in the bench works out each result,
// and every result transfer is compared with it field by field. The run has
// directed cases (empty table, entry updates, circular victim scan with
// wrap and fallback, unused opcodes), a receiver hold-off that backs the
// block up, and a long random mix sent in bursts with a stalling receiver.
// ----------------------------------------------------------------------------
module page_table_with_victim_select_core_test;
  import ptvs_pkg::*;

  localparam int PT_PAGES        = PAGES_DEF;
  localparam int PT_FRAMES       = FRAMES_DEF;
  localparam int RANDOM_ITEMS    = 1800;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int SETTLE_CYCLES   = 300;

  localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [FRAME_W-1:0]    frame_out;
    logic                  hit;
    logic [PAGE_IDX_W-1:0] page_out;
    logic                  entry_valid;
    logic                  entry_readonly;
    logic [CNT_W-1:0]      lookups_seen;
    logic [CNT_W-1:0]      faults_seen;
    logic [CNT_W-1:0]      sets_seen;
  } page_result_t;

  logic clk = 1'b0;
  logic rst_n;

  ptvs_in_if  in_ch ();
  ptvs_out_if out_ch ();

  page_table_with_victim_select_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  // shadow page table
  logic               pt_valid [PT_PAGES];
  logic               pt_ro    [PT_PAGES];
  logic [FRAME_W-1:0] pt_frame [PT_PAGES];
  logic [CNT_W-1:0]   lookup_count;
  logic [CNT_W-1:0]   fault_count;
  logic [CNT_W-1:0]   set_count;

  page_result_t outcome_queue[$];
  int           fail_count    = 0;
  bit           hold_off_req  = 1'b0;
  bit           hold_active   = 1'b0;

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic page_result_t page_op_outcome(
    logic [OPCODE_W-1:0] op, logic [PAGE_IDX_W-1:0] page, logic [FRAME_W-1:0] frame,
    logic ro, logic [PAGE_IDX_W-1:0] rstart, logic [FRAME_W-1:0] rframe);
    page_result_t r;
    int           idx;
    int           first;
    r = '0;
    case (op)
      OP_LOOKUP: begin
        lookup_count = sat_inc(lookup_count);
        if (pt_valid[page]) begin
          r.frame_out = pt_frame[page];
          r.hit       = 1'b1;
        end else begin
          fault_count = sat_inc(fault_count);
        end
      end
      OP_SET: begin
        set_count      = sat_inc(set_count);
        pt_valid[page] = 1'b1;
        pt_ro[page]    = 1'b1;
        pt_frame[page] = frame;
      end
      OP_UNSET:  pt_valid[page] = 1'b0;
      OP_SET_RO: pt_ro[page] = ro;
      OP_FIND: begin
        for (idx = 0; idx < PT_PAGES; idx++) begin
          if (pt_frame[idx] == frame) begin
            r.page_out = idx[PAGE_IDX_W-1:0];
            r.hit      = 1'b1;
            break;
          end
        end
      end
      OP_VICTIM: begin
        first = int'(rstart) % PT_PAGES;
        for (int i = 0; i < PT_PAGES; i++) begin
          idx = (first + i) % PT_PAGES;
          if (pt_valid[idx] && !pt_ro[idx]) begin
            r.frame_out = pt_frame[idx];
            r.hit       = 1'b1;
            break;
          end
        end
        if (!r.hit) r.frame_out = FRAME_W'(int'(rframe) % PT_FRAMES);
      end
      default: ;
    endcase
    r.entry_valid    = pt_valid[page];
    r.entry_readonly = pt_ro[page];
    r.lookups_seen   = lookup_count;
    r.faults_seen    = fault_count;
    r.sets_seen      = set_count;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    page_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (outcome_queue.size() == 0) begin
        $error("result transfer with nothing outstanding");
        fail_count++;
      end else begin
        want = outcome_queue.pop_front();
        check_field("frame_out", 32'(want.frame_out), 32'(out_ch.frame_out));
        check_field("hit", 32'(want.hit), 32'(out_ch.hit));
        check_field("page_out", 32'(want.page_out), 32'(out_ch.page_out));
        check_field("entry_valid", 32'(want.entry_valid), 32'(out_ch.entry_valid));
        check_field("entry_readonly", 32'(want.entry_readonly),
                    32'(out_ch.entry_readonly));
        check_field("lookups_seen", want.lookups_seen, out_ch.lookups_seen);
        check_field("faults_seen", want.faults_seen, out_ch.faults_seen);
        check_field("sets_seen", want.sets_seen, out_ch.sets_seen);
      end
    end
  end

  // receiver: random ready pattern, plus a long hold-off on request
  initial begin
    int run_len;
    int stall_len;
    forever begin
      if (hold_off_req) begin
        hold_active = 1'b1;
        repeat (HOLD_OFF_CYCLES) begin
          out_ch.ready <= 1'b0;
          @(posedge clk);
        end
        hold_active  = 1'b0;
        hold_off_req = 1'b0;
      end else begin
        run_len   = $urandom_range(1, 40);
        stall_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        repeat (run_len) begin
          out_ch.ready <= 1'b1;
          @(posedge clk);
        end
        repeat (stall_len) begin
          out_ch.ready <= 1'b0;
          @(posedge clk);
        end
      end
    end
  end

  // call at a rising edge; returns at the edge of the transfer with valid still high
  task automatic send_op(
    logic [OPCODE_W-1:0] op, logic [PAGE_IDX_W-1:0] page, logic [FRAME_W-1:0] frame,
    logic ro, logic [PAGE_IDX_W-1:0] rstart, logic [FRAME_W-1:0] rframe);
    in_ch.valid          <= 1'b1;
    in_ch.opcode         <= op;
    in_ch.page_index     <= page;
    in_ch.frame_in       <= frame;
    in_ch.readonly_value <= ro;
    in_ch.random_start   <= rstart;
    in_ch.random_frame   <= rframe;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    outcome_queue.push_back(page_op_outcome(op, page, frame, ro, rstart, rframe));
  endtask

  task automatic idle_gap(int n);
    if (n == 0) return;
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic test_empty_table();
    send_op(OP_LOOKUP, 8'd0, 5'd0, 1'b0, 8'd0, 5'd0);
    send_op(OP_LOOKUP, 8'd255, 5'd31, 1'b1, 8'd255, 5'd31);
    send_op(OP_FIND, 8'd0, 5'd31, 1'b0, 8'd0, 5'd0);
    send_op(OP_FIND, 8'd0, 5'd0, 1'b0, 8'd0, 5'd0);
    send_op(OP_VICTIM, 8'd0, 5'd0, 1'b0, 8'd255, 5'd31);
    idle_gap(1);
  endtask

  task automatic test_entry_updates();
    send_op(OP_SET, 8'd255, 5'd31, 1'b0, 8'd0, 5'd0);
    send_op(OP_SET, 8'd128, 5'd10, 1'b0, 8'd0, 5'd0);
    send_op(OP_LOOKUP, 8'd255, 5'd0, 1'b0, 8'd0, 5'd0);
    send_op(OP_UNSET, 8'd255, 5'd0, 1'b0, 8'd0, 5'd0);
    send_op(OP_LOOKUP, 8'd255, 5'd0, 1'b0, 8'd0, 5'd0);
    // search ignores the valid bit
    send_op(OP_FIND, 8'd0, 5'd31, 1'b0, 8'd0, 5'd0);
    send_op(OP_SET, 8'd255, 5'd31, 1'b0, 8'd0, 5'd0);
    idle_gap(2);
  endtask

  task automatic test_victim_select();
    send_op(OP_VICTIM, 8'd0, 5'd0, 1'b0, 8'd0, 5'd0);
    send_op(OP_SET_RO, 8'd255, 5'd0, 1'b0, 8'd0, 5'd0);
    send_op(OP_VICTIM, 8'd0, 5'd0, 1'b0, 8'd0, 5'd7);
    send_op(OP_SET_RO, 8'd128, 5'd0, 1'b0, 8'd0, 5'd0);
    send_op(OP_VICTIM, 8'd0, 5'd0, 1'b0, 8'd200, 5'd0);
    send_op(OP_VICTIM, 8'd0, 5'd0, 1'b0, 8'd0, 5'd0);
    send_op(OP_UNSET, 8'd255, 5'd0, 1'b0, 8'd0, 5'd0);
    // wraps past the top of the table
    send_op(OP_VICTIM, 8'd0, 5'd0, 1'b0, 8'd200, 5'd0);
    send_op(OP_SET_RO, 8'd128, 5'd0, 1'b1, 8'd0, 5'd0);
    send_op(OP_VICTIM, 8'd0, 5'd0, 1'b0, 8'd129, 5'd21);
    idle_gap(1);
  endtask

  task automatic test_unused_opcodes();
    send_op(OP_SPARE_6, 8'd128, 5'd31, 1'b1, 8'd255, 5'd31);
    send_op(OP_SPARE_7, 8'd255, 5'd0, 1'b0, 8'd0, 5'd0);
    idle_gap(1);
  endtask

  function automatic logic [OPCODE_W-1:0] pick_opcode();
    int w;
    w = $urandom_range(0, 99);
    if (w < 25) return OP_LOOKUP;
    if (w < 45) return OP_SET;
    if (w < 53) return OP_UNSET;
    if (w < 68) return OP_SET_RO;
    if (w < 80) return OP_FIND;
    if (w < 95) return OP_VICTIM;
    return (w < 97) ? OP_SPARE_6 : OP_SPARE_7;
  endfunction

  // half the traffic hits a few pages at each end of the table
  function automatic logic [PAGE_IDX_W-1:0] pick_page();
    case ($urandom_range(0, 3))
      0:       return PAGE_IDX_W'($urandom_range(0, 7));
      1:       return PAGE_IDX_W'($urandom_range(248, 255));
      default: return PAGE_IDX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_op();
    logic [OPCODE_W-1:0]   op;
    logic [PAGE_IDX_W-1:0] page;
    logic [FRAME_W-1:0]    frame;
    logic                  ro;
    op    = pick_opcode();
    page  = pick_page();
    frame = FRAME_W'($urandom_range(0, 31));
    if (op == OP_FIND && $urandom_range(0, 1) == 1) frame = pt_frame[pick_page()];
    ro    = ($urandom_range(0, 9) < 7) ? 1'b0 : 1'b1;
    send_op(op, page, frame, ro, PAGE_IDX_W'($urandom), FRAME_W'($urandom));
  endtask

  task automatic test_backpressure();
    hold_off_req = 1'b1;
    while (!hold_active) @(posedge clk);
    repeat (12) send_random_op();
    idle_gap(1);
    while (hold_off_req) @(posedge clk);
  endtask

  task automatic test_random_mix();
    int sent;
    int burst;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        send_random_op();
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 10));
    end
    idle_gap(1);
  endtask

  initial begin
    int waited;
    for (int i = 0; i < PT_PAGES; i++) begin
      pt_valid[i] = 1'b0;
      pt_ro[i]    = 1'b0;
      pt_frame[i] = '0;
    end
    lookup_count = '0;
    fault_count  = '0;
    set_count    = '0;

    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.opcode         <= '0;
    in_ch.page_index     <= '0;
    in_ch.frame_in       <= '0;
    in_ch.readonly_value <= 1'b0;
    in_ch.random_start   <= '0;
    in_ch.random_frame   <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_entry_updates();
    test_victim_select();
    test_unused_opcodes();
    test_backpressure();
    test_random_mix();

    waited = 0;
    while (outcome_queue.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (outcome_queue.size() != 0) begin
      $error("%0d results never arrived", outcome_queue.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("page_table_with_victim_select_core verification clean");
    end else begin
      $display("page_table_with_victim_select_core verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("page_table_with_victim_select_core verification failed");
    $finish;
  end

endmodule

// File: sim.f
design/ptvs_pkg.sv
design/ptvs_intf.sv
design/ptvs_reduce.sv
design/page_table_with_victim_select_core.sv
dv/page_table_with_victim_select_core_test.sv
